// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define MRM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mrm_pkg.sv =====
// ----------------------------------------------------------------------------
// mrm_pkg
// Types, codes and helpers shared by the Modbus-RTU master frame engine.
// ----------------------------------------------------------------------------
package mrm_pkg;

    localparam int RESP_BYTES_DEF = 64;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0]  FC_READ  = 8'h03;
    localparam logic [7:0]  FC_WRITE = 8'h06;
    localparam logic [7:0]  EXC_BIT  = 8'h80;
    localparam logic [7:0]  FC_MASK  = 8'h7F;

    typedef enum logic [1:0] {
        CMD_READ    = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_BYTE    = 2'd2,
        CMD_TIMEOUT = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_TX     = 2'd0,
        KIND_WORD   = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_TIMEOUT = 3'd1,
        ST_CRC     = 3'd2,
        ST_INVALID = 3'd3,
        ST_SIZE    = 3'd4
    } t_status;

    typedef struct packed {
        logic       init;
        logic       load;
        logic [7:0] data;
    } t_crc_ctl;

    typedef struct packed {
        logic        busy;
        logic [15:0] crc;
    } t_crc_sts;

    function automatic logic [15:0] crc_shift(input logic [15:0] c);
        crc_shift = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    endfunction

endpackage

// ===== sv/mrm_crc_unit.sv =====
// ----------------------------------------------------------------------------
// mrm_crc_unit
// Bit-serial CRC-16 engine: one byte is folded in over eight shift steps.
// ----------------------------------------------------------------------------
module mrm_crc_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mrm_pkg::t_crc_ctl i_ctl,
    output mrm_pkg::t_crc_sts o_sts
);
    import mrm_pkg::*;

    logic [15:0] r_crc;
    logic [3:0]  r_cnt;
    logic [15:0] n_crc;
    logic [3:0]  n_cnt;

    always_comb begin
        n_crc = r_crc;
        n_cnt = r_cnt;
        if (i_ctl.init) begin
            n_crc = CRC_INIT;
            n_cnt = 4'd0;
        end else if (i_ctl.load) begin
            n_crc = r_crc ^ {8'h00, i_ctl.data};
            n_cnt = 4'd8;
        end else if (r_cnt != 4'd0) begin
            n_crc = crc_shift(r_crc);
            n_cnt = r_cnt - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
            r_cnt <= 4'd0;
        end else begin
            r_crc <= n_crc;
            r_cnt <= n_cnt;
        end
    end

    assign o_sts.busy = (r_cnt != 4'd0);
    assign o_sts.crc  = r_crc;

endmodule

// ===== sv/mrm_word_mem.sv =====
// ----------------------------------------------------------------------------
// mrm_word_mem
// Register word buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mrm_word_mem #(
    parameter int DEPTH = 29,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [15:0]   o_rdata
);
    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/modbus_rtu_master_frame_engine.sv =====
// ----------------------------------------------------------------------------
// modbus_rtu_master_frame_engine
// Modbus-RTU master framing for read holding (0x03) and write single (0x06).
// ----------------------------------------------------------------------------
// A start command sends each of the six request bytes through the bit-serial
// CRC unit before it is emitted, then the two CRC bytes follow. Each response
// byte is folded in by the same CRC unit (load, eight shift steps, then
// hand-back) before the input is ready again. When the last byte of a frame
// arrives, the check runs, then each register word is sent (registered read of
// the word buffer, then the beat), then the status. A timeout or an oversized
// read goes through the status state, and its status beat is registered.
// Ignored bytes and ignored timeouts leave the input ready. Output
// backpressure can stall every beat.
`include "assert_macros.svh"

module modbus_rtu_master_frame_engine #(
    parameter int RESP_BYTES = mrm_pkg::RESP_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // slave[7:0], reg_addr[23:8], count_or_value[39:24], rx_byte[47:40]
    input  logic [47:0] s_axis_tdata,
    // command[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // data[15:0], status[18:16], exception_code[26:19], zero[31:27]
    output logic [31:0] m_axis_tdata,
    // kind[1:0]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    import mrm_pkg::*;

    localparam int MAX_WORDS = (RESP_BYTES - 5) / 2;
    localparam int CW        = $clog2(RESP_BYTES + 1);
    localparam int WCW       = $clog2(MAX_WORDS + 1);
    localparam int AW        = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TX_CRC,
        S_TX_WAIT,
        S_TX_LO,
        S_TX_HI,
        S_RX_WAIT,
        S_CHECK,
        S_WRD_RD,
        S_WRD_OUT,
        S_STATUS
    } t_state;

    t_state         r_state;
    logic           r_busy;
    logic [7:0]     r_want_slave;
    logic [7:0]     r_want_fc;
    logic [15:0]    r_req_addr;
    logic [15:0]    r_req_cv;
    logic [WCW-1:0] r_wc;
    logic [CW-1:0]  r_exp;
    logic [CW-1:0]  r_rcvd;
    logic [15:0]    r_crc5;
    logic [7:0]     r_hdr [3];
    logic [7:0]     r_hold;
    logic [2:0]     r_idx;
    logic [WCW-1:0] r_widx;
    logic           r_done_rx;
    t_status        r_stat;
    logic [7:0]     r_exc;

    logic           r_m_valid;
    t_kind          r_m_kind;
    logic [15:0]    r_m_data;
    t_status        r_m_status;
    logic [7:0]     r_m_exc;
    logic           r_m_last;

    t_crc_ctl       w_crc_ctl;
    t_crc_sts       w_crc_sts;

    t_cmd           w_cmd;
    logic           w_in_fire;
    logic [7:0]     w_slave;
    logic [15:0]    w_addr;
    logic [15:0]    w_cv;
    logic [7:0]     w_rx;
    logic [17:0]    w_expect;
    logic           w_too_big;
    logic [CW-1:0]  w_off;
    logic           w_in_words;
    logic           w_out_free;
    logic [7:0]     w_req_byte;
    logic           w_hdr_bad;
    logic           w_mem_we;
    logic [15:0]    w_mem_rdata;

    assign w_cmd      = t_cmd'(s_axis_tuser);
    assign w_slave    = s_axis_tdata[7:0];
    assign w_addr     = s_axis_tdata[23:8];
    assign w_cv       = s_axis_tdata[39:24];
    assign w_rx       = s_axis_tdata[47:40];
    assign w_in_fire  = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_m_valid || m_axis_tready;

    assign w_expect   = 18'd5 + {1'b0, w_cv, 1'b0};
    assign w_too_big  = (w_cmd == CMD_READ) && (w_expect > 18'(RESP_BYTES));

    assign w_off      = r_rcvd - CW'(3);
    assign w_in_words = (r_want_fc == FC_READ) && (r_rcvd >= CW'(3))
                        && ((CW+1)'(w_off) < (CW+1)'({r_wc, 1'b0}));

    assign w_hdr_bad  = (r_hdr[0] != r_want_slave)
                        || ((r_hdr[1] & FC_MASK) != (r_want_fc & FC_MASK))
                        || ((r_hdr[1] & EXC_BIT) != 8'h00)
                        || ((r_want_fc == FC_READ) && (r_hdr[2] != 8'({r_wc, 1'b0})));

    always_comb begin
        unique case (r_idx)
            3'd0:    w_req_byte = r_want_slave;
            3'd1:    w_req_byte = r_want_fc;
            3'd2:    w_req_byte = r_req_addr[15:8];
            3'd3:    w_req_byte = r_req_addr[7:0];
            3'd4:    w_req_byte = r_req_cv[15:8];
            3'd5:    w_req_byte = r_req_cv[7:0];
            default: w_req_byte = 8'h00;
        endcase
    end

    always_comb begin
        w_crc_ctl = '0;
        priority if (r_state == S_IDLE && w_in_fire
                     && (w_cmd == CMD_READ || w_cmd == CMD_WRITE) && !w_too_big) begin
            w_crc_ctl.init = 1'b1;
        end else if (r_state == S_IDLE && w_in_fire && w_cmd == CMD_BYTE && r_busy) begin
            w_crc_ctl.load = 1'b1;
            w_crc_ctl.data = w_rx;
        end else if (r_state == S_TX_CRC) begin
            w_crc_ctl.load = 1'b1;
            w_crc_ctl.data = w_req_byte;
        end else if (r_state == S_TX_HI && w_out_free) begin
            w_crc_ctl.init = 1'b1;
        end else begin
            w_crc_ctl = '0;
        end
    end

    assign w_mem_we = w_in_fire && (w_cmd == CMD_BYTE) && r_busy && w_in_words && w_off[0];

    mrm_crc_unit u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_crc_ctl),
        .o_sts   (w_crc_sts)
    );

    mrm_word_mem #(
        .DEPTH (MAX_WORDS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (AW'(w_off >> 1)),
        .i_wdata ({r_hold, w_rx}),
        .i_re    (r_state == S_WRD_RD),
        .i_raddr (AW'(r_widx)),
        .o_rdata (w_mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_busy       <= 1'b0;
            r_want_slave <= 8'h00;
            r_want_fc    <= 8'h00;
            r_wc         <= '0;
            r_exp        <= '0;
            r_rcvd       <= '0;
            r_crc5       <= 16'h0000;
            r_hdr        <= '{default: 8'h00};
            r_hold       <= 8'h00;
            r_idx        <= 3'd0;
            r_widx       <= '0;
            r_done_rx    <= 1'b0;
            r_m_valid    <= 1'b0;
            r_m_last     <= 1'b0;
        end else begin
            if (r_m_valid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        unique case (w_cmd)
                            CMD_READ, CMD_WRITE: begin
                                r_busy <= 1'b0;
                                if (w_too_big) begin
                                    r_stat  <= ST_SIZE;
                                    r_exc   <= 8'h00;
                                    r_state <= S_STATUS;
                                end else begin
                                    r_want_slave <= w_slave;
                                    r_req_addr   <= w_addr;
                                    r_req_cv     <= w_cv;
                                    r_idx        <= 3'd0;
                                    r_state      <= S_TX_CRC;
                                    if (w_cmd == CMD_READ) begin
                                        r_want_fc <= FC_READ;
                                        r_wc      <= WCW'(w_cv);
                                        r_exp     <= CW'(w_expect);
                                    end else begin
                                        r_want_fc <= FC_WRITE;
                                        r_wc      <= '0;
                                        r_exp     <= CW'(8);
                                    end
                                end
                            end
                            CMD_BYTE: begin
                                if (r_busy) begin
                                    if (r_rcvd < CW'(3)) begin
                                        r_hdr[r_rcvd[1:0]] <= w_rx;
                                    end
                                    if (w_in_words && !w_off[0]) begin
                                        r_hold <= w_rx;
                                    end
                                    r_rcvd    <= r_rcvd + CW'(1);
                                    r_done_rx <= ((r_rcvd + CW'(1)) >= r_exp);
                                    r_state   <= S_RX_WAIT;
                                end
                            end
                            CMD_TIMEOUT: begin
                                if (r_busy) begin
                                    r_busy  <= 1'b0;
                                    r_state <= S_STATUS;
                                    if (r_rcvd >= CW'(5) && (r_hdr[1] & EXC_BIT) != 8'h00
                                        && r_crc5 == 16'h0000) begin
                                        r_stat <= ST_INVALID;
                                        r_exc  <= r_hdr[2];
                                    end else begin
                                        r_stat <= ST_TIMEOUT;
                                        r_exc  <= 8'h00;
                                    end
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_TX_CRC: begin
                    r_state <= S_TX_WAIT;
                end
                S_TX_WAIT: begin
                    if (!w_crc_sts.busy && w_out_free) begin
                        r_m_valid  <= 1'b1;
                        r_m_kind   <= KIND_TX;
                        r_m_data   <= {8'h00, w_req_byte};
                        r_m_status <= ST_OK;
                        r_m_exc    <= 8'h00;
                        r_m_last   <= 1'b0;
                        r_idx      <= r_idx + 3'd1;
                        r_state    <= (r_idx == 3'd5) ? S_TX_LO : S_TX_CRC;
                    end
                end
                S_TX_LO: begin
                    if (w_out_free) begin
                        r_m_valid  <= 1'b1;
                        r_m_kind   <= KIND_TX;
                        r_m_data   <= {8'h00, w_crc_sts.crc[7:0]};
                        r_m_status <= ST_OK;
                        r_m_exc    <= 8'h00;
                        r_m_last   <= 1'b0;
                        r_state    <= S_TX_HI;
                    end
                end
                S_TX_HI: begin
                    if (w_out_free) begin
                        r_m_valid  <= 1'b1;
                        r_m_kind   <= KIND_TX;
                        r_m_data   <= {8'h00, w_crc_sts.crc[15:8]};
                        r_m_status <= ST_OK;
                        r_m_exc    <= 8'h00;
                        r_m_last   <= 1'b1;
                        r_busy     <= 1'b1;
                        r_rcvd     <= '0;
                        r_crc5     <= 16'h0000;
                        r_hdr      <= '{default: 8'h00};
                        r_hold     <= 8'h00;
                        r_state    <= S_IDLE;
                    end
                end
                S_RX_WAIT: begin
                    if (!w_crc_sts.busy) begin
                        if (r_rcvd == CW'(5)) begin
                            r_crc5 <= w_crc_sts.crc;
                        end
                        r_state <= r_done_rx ? S_CHECK : S_IDLE;
                    end
                end
                S_CHECK: begin
                    r_busy <= 1'b0;
                    r_exc  <= 8'h00;
                    r_widx <= '0;
                    priority if (w_crc_sts.crc != 16'h0000) begin
                        r_stat  <= ST_CRC;
                        r_state <= S_STATUS;
                    end else if (w_hdr_bad) begin
                        r_stat  <= ST_INVALID;
                        r_state <= S_STATUS;
                    end else if (r_want_fc == FC_READ && r_wc != '0) begin
                        r_stat  <= ST_OK;
                        r_state <= S_WRD_RD;
                    end else begin
                        r_stat  <= ST_OK;
                        r_state <= S_STATUS;
                    end
                end
                S_WRD_RD: begin
                    r_state <= S_WRD_OUT;
                end
                S_WRD_OUT: begin
                    if (w_out_free) begin
                        r_m_valid  <= 1'b1;
                        r_m_kind   <= KIND_WORD;
                        r_m_data   <= w_mem_rdata;
                        r_m_status <= ST_OK;
                        r_m_exc    <= 8'h00;
                        r_m_last   <= 1'b0;
                        r_widx     <= r_widx + WCW'(1);
                        r_state    <= ((r_widx + WCW'(1)) == r_wc) ? S_STATUS : S_WRD_RD;
                    end
                end
                S_STATUS: begin
                    if (w_out_free) begin
                        r_m_valid  <= 1'b1;
                        r_m_kind   <= KIND_STATUS;
                        r_m_data   <= 16'h0000;
                        r_m_status <= r_stat;
                        r_m_exc    <= r_exc;
                        r_m_last   <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {5'b00000, r_m_exc, r_m_status, r_m_data};
    assign m_axis_tuser  = r_m_kind;
    assign m_axis_tlast  = r_m_last;

    `MRM_ASSERT_IMPL(a_idle_crc_quiet, s_axis_tready, !w_crc_sts.busy, "CRC unit busy while ready")
    `MRM_ASSERT_NEXT(a_crc_load_busy, r_state == S_TX_CRC, w_crc_sts.busy, "CRC load not started")
    `MRM_ASSERT_IMPL(a_status_last, r_m_valid && r_m_kind == KIND_STATUS, r_m_last, "Status beat without last")
    `MRM_ASSERT_IMPL(a_rx_count, r_busy && r_state == S_IDLE, r_rcvd < r_exp, "Receive count reached frame length while waiting")

endmodule
